// File: hw/rtl/bdq_pkg.sv
// Package for the bounded deque core: command and result transfer types,
// operation codes. No dependencies.
`default_nettype none

package bdq_pkg;

	localparam int WORD_W  = 32;
	localparam int OP_W    = 4;
	localparam int DCOUNT_W = 6;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_REMOVE     = 4'd4,
		OP_DUMP_FIRST = 4'd5,
		OP_DUMP_LAST  = 4'd6,
		OP_DUMP_ALL   = 4'd7,
		OP_CLEAR      = 4'd8
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]        operation;
		logic signed [WORD_W-1:0] item_value;
		logic [DCOUNT_W-1:0]    dump_count;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] entry_value;
		logic                   has_entry;
		logic                   last_of_dump;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bdq_mem.sv
// Entry storage of the bounded deque: one write port, one read port with
// registered read data. Uses bdq_pkg for the word width.
`default_nettype none

module bdq_mem import bdq_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [IDX_W-1:0]          waddr,
	input  wire signed [WORD_W-1:0]  wdata,
	input  wire [IDX_W-1:0]          raddr,
	output logic signed [WORD_W-1:0] rdata
);

	logic signed [WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_deque_with_value_delete_core.sv
// Top level of the bounded deque core: command decode, end pointers, walk
// sequencer for remove and dump. Depends on bdq_pkg and bdq_mem.
`default_nettype none

// Bounded double-ended queue of up to DEPTH signed 32-bit words.
//
// Command channel: drive cmd and raise start; the transfer happens at the
// rising edge where start is high and busy is low. Result channel: each
// result sits on result for exactly one cycle with result_strobe high; the
// receiver must take it then, it cannot stall the core.
//
// Command behaviour:
//   push / pop / clear / unknown op : no result, busy stays low.
//   dump of an empty selection     : one marker result the cycle after the
//                                    transfer, busy stays low.
//   dump of N entries              : busy while the walk runs; one result per cycle
//                                    behind the registered memory read; the last
//                                    comes while busy is already low again.
//   remove value over L entries    : busy while the walk runs, no result.
// The entry memory has registered read data, so busy holds until the last read
// returns; the longest command is a remove or dump over a full deque.
// Survivors of a remove are written back behind the read offset: no forwarding.
// Reset empties the deque; the entry memory itself is not cleared.
module bounded_deque_with_value_delete_core import bdq_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire cmd_t  cmd,
	output logic       busy,
	output logic       result_strobe,
	output result_t    result
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int MW    = (CNT_W > DCOUNT_W) ? CNT_W : DCOUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_REMOVE = 3'b010,
		ST_DUMP   = 3'b100
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        front_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [WORD_W-1:0] val_q;
	logic [CNT_W-1:0]        rd_off_q;
	logic [CNT_W-1:0]        end_off_q;
	logic [CNT_W-1:0]        wr_off_q;
	logic                    rd_vld_s1;
	logic                    rd_last_s1;
	logic                    rd_rm_s1;
	result_t                 result_q;
	logic                    strobe_q;

	logic                    accept;
	logic                    full;
	logic                    empty;
	logic [MW-1:0]           dcnt_ext;
	logic [MW-1:0]           count_ext;
	logic [MW-1:0]           sel_ext;
	logic [CNT_W-1:0]        sel_n;
	logic [CNT_W-1:0]        rd_off_nxt;
	logic [IDX_W-1:0]        front_dec;
	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	logic signed [WORD_W-1:0] mem_wdata;
	logic [IDX_W-1:0]        mem_raddr;
	logic signed [WORD_W-1:0] mem_rdata;
	logic                    keep_s1;

	// Map an offset from the front to a memory slot; offset is at most DEPTH.
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
	                                             input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	assign busy   = (state_q != ST_IDLE) || rd_vld_s1;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	// Clip the dump length to the current length.
	assign dcnt_ext  = MW'(cmd.dump_count);
	assign count_ext = MW'(count_q);
	assign sel_ext   = (dcnt_ext < count_ext) ? dcnt_ext : count_ext;
	assign sel_n     = sel_ext[CNT_W-1:0];

	assign front_dec  = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign rd_off_nxt = rd_off_q + 1'b1;
	assign mem_raddr  = slot_of(front_q, rd_off_q);
	assign keep_s1    = (mem_rdata != val_q);

	// Single write port: pushes in idle, compaction write-back during remove.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_of(front_q, wr_off_q);
		mem_wdata = mem_rdata;
		if (rd_vld_s1 && rd_rm_s1) begin
			mem_we = keep_s1;
		end else if (accept && !full) begin
			if (cmd.operation == OP_PUSH_FRONT) begin
				mem_we    = 1'b1;
				mem_waddr = front_dec;
				mem_wdata = cmd.item_value;
			end else if (cmd.operation == OP_PUSH_BACK) begin
				mem_we    = 1'b1;
				mem_waddr = slot_of(front_q, count_q);
				mem_wdata = cmd.item_value;
			end
		end
	end

	bdq_mem #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Command decode and walk sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			rd_off_q   <= '0;
			end_off_q  <= '0;
			wr_off_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_rm_s1   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q  <= 1'b0;
			rd_vld_s1 <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.operation)
							OP_PUSH_FRONT: begin
								if (!full) begin
									front_q <= front_dec;
									count_q <= count_q + 1'b1;
								end
							end
							OP_PUSH_BACK: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_POP_FRONT: begin
								if (!empty) begin
									front_q <= slot_of(front_q, CNT_W'(1));
									count_q <= count_q - 1'b1;
								end
							end
							OP_POP_BACK: begin
								if (!empty) begin
									count_q <= count_q - 1'b1;
								end
							end
							OP_REMOVE: begin
								// Walk only when something is stored.
								rd_off_q  <= '0;
								wr_off_q  <= '0;
								end_off_q <= count_q;
								if (!empty) begin
									state_q <= ST_REMOVE;
								end
							end
							OP_DUMP_FIRST, OP_DUMP_LAST: begin
								wr_off_q  <= '0;
								rd_off_q  <= (cmd.operation == OP_DUMP_LAST) ?
								             count_q - sel_n : '0;
								end_off_q <= (cmd.operation == OP_DUMP_LAST) ?
								             count_q : sel_n;
								if (sel_n == '0) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= ST_DUMP;
								end
							end
							OP_DUMP_ALL: begin
								wr_off_q  <= '0;
								rd_off_q  <= '0;
								end_off_q <= count_q;
								if (empty) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= ST_DUMP;
								end
							end
							OP_CLEAR: begin
								front_q <= '0;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_REMOVE, ST_DUMP: begin
					// Issue one read per cycle; drop back to idle after the last.
					rd_vld_s1  <= 1'b1;
					rd_rm_s1   <= (state_q == ST_REMOVE);
					rd_last_s1 <= (rd_off_nxt == end_off_q);
					rd_off_q   <= rd_off_nxt;
					if (rd_off_nxt == end_off_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Read data stage: compact on remove, emit on dump.
			if (rd_vld_s1) begin
				if (rd_rm_s1) begin
					if (keep_s1) begin
						wr_off_q <= wr_off_q + 1'b1;
					end
					if (rd_last_s1) begin
						count_q <= wr_off_q + CNT_W'(keep_s1);
					end
				end else begin
					strobe_q <= 1'b1;
				end
			end
		end
	end

	// Result register: payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= cmd.item_value;
		end
		if (rd_vld_s1 && !rd_rm_s1) begin
			result_q.entry_value  <= mem_rdata;
			result_q.has_entry    <= 1'b1;
			result_q.last_of_dump <= rd_last_s1;
		end else begin
			result_q.entry_value  <= '0;
			result_q.has_entry    <= 1'b0;
			result_q.last_of_dump <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

`ifndef SYNTH
	// Stored length never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("deque length exceeds capacity");

	// Compaction write offset never overtakes the read offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REMOVE || (rd_vld_s1 && rd_rm_s1)) |-> wr_off_q <= rd_off_q)
		else $error("remove write-back overtook the read walk");

	// An empty marker always closes its dump.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.has_entry) |-> result.last_of_dump)
		else $error("empty marker not flagged as last of dump");

	// A remove never emits results.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && rd_rm_s1) |=> !result_strobe)
		else $error("result emitted during remove");
`endif

endmodule

`default_nettype wire
